>>> hdl/pgf2d_pkg.sv
// Shared widths, register indexes, reset values and stage payload types for the gravity pipeline.
package pgf2d_pkg;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_CONSTANT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEPARATION = CFG_IDX_W'(1);

    localparam logic [31:0] GRAV_CONSTANT_RESET  = 32'd65536;
    localparam logic [31:0] MIN_SEPARATION_RESET = 32'd655;

    // Root of a sum of two 64-bit squares needs 33 bits.
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 66;
    localparam int TRIAL_W     = 68;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int GMM_W       = 96;
    localparam int NUM_W       = 128;
    localparam int DEN_W       = 99;
    localparam int RDIV_W      = DEN_W + 1;
    localparam int Q_W         = 64;
    localparam int DIV_STEPS   = Q_W;
    localparam int NUM_HI_LSB  = Q_W - 16;

    localparam logic [Q_W-1:0] FORCE_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] FORCE_NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [GMM_W-1:0]  gmm;
        logic [31:0]       ax;
        logic [31:0]       ay;
        logic              negx;
        logic              negy;
        logic              close;
    } sqrt_stage_t;

    typedef struct packed {
        logic [RDIV_W-1:0] rx;
        logic [RDIV_W-1:0] ry;
        logic [Q_W-1:0]    lowx;
        logic [Q_W-1:0]    lowy;
        logic [Q_W-1:0]    qx;
        logic [Q_W-1:0]    qy;
        logic [DEN_W-1:0]  den;
        logic              bigx;
        logic              bigy;
        logic              negx;
        logic              negy;
        logic              close;
    } div_stage_t;

endpackage

>>> hdl/pairwise_gravity_force_2d.sv
// Pipelined 2D Newtonian gravity force between two bodies, fixed point.
// Throughput: one request per cycle; a stalled output freezes the pipeline only once
// its last stage holds a result, so bubbles are squeezed out while the output waits.
// Reset (aresetn low, synchronous) empties every stage and restores G to 1.0 and the
// minimum separation to 655 (about 0.01); stage payloads are not reset.
module pairwise_gravity_force_2d (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pgf2d_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_first_pos_x,
    input  logic signed [31:0]              s_first_pos_y,
    input  logic signed [31:0]              s_second_pos_x,
    input  logic signed [31:0]              s_second_pos_y,
    input  logic [31:0]                     s_first_mass,
    input  logic [31:0]                     s_second_mass,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [63:0]              m_first_force_x,
    output logic signed [63:0]              m_first_force_y,
    output logic signed [63:0]              m_second_force_x,
    output logic signed [63:0]              m_second_force_y,
    output logic                            m_force_active,
    output logic                            m_saturated
);
    import pgf2d_pkg::*;

    // Configuration registers. Writes are always taken; unknown indexes are dropped.
    logic [31:0] grav_reg;
    logic [31:0] minsep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grav_reg   <= GRAV_CONSTANT_RESET;
            minsep_reg <= MIN_SEPARATION_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_GRAV_CONSTANT) begin
                grav_reg <= cfg_data;
            end
            if (cfg_index == CFG_MIN_SEPARATION) begin
                minsep_reg <= cfg_data;
            end
        end
    end

    // Pipeline advance. The whole pipeline shifts together; it may shift while the
    // output register waits as long as the last stage is empty, so nothing is lost.
    logic out_valid_reg;
    logic out_free;
    logic en;
    logic div_valid_reg [0:DIV_STEPS];

    assign out_free = ~out_valid_reg | m_ready;
    assign en       = out_free | ~div_valid_reg[DIV_STEPS];
    assign s_ready  = en;

    // Stage 1: coordinate differences and their magnitudes.
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               s1_valid_reg;
    logic [31:0]        s1_ax_reg, s1_ay_reg, s1_m1_reg, s1_m2_reg;
    logic               s1_negx_reg, s1_negy_reg;

    always_comb begin
        dx = 33'(s_second_pos_x) - 33'(s_first_pos_x);
        dy = 33'(s_second_pos_y) - 33'(s_first_pos_y);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
        if (en) begin
            s1_ax_reg   <= dx[32] ? 32'(-dx) : dx[31:0];
            s1_ay_reg   <= dy[32] ? 32'(-dy) : dy[31:0];
            s1_negx_reg <= dx[32];
            s1_negy_reg <= dy[32];
            s1_m1_reg   <= s_first_mass;
            s1_m2_reg   <= s_second_mass;
        end
    end

    // Stage 2: squares of the differences, the squared threshold and G*m1.
    logic        s2_valid_reg;
    logic [63:0] s2_sqx_reg, s2_sqy_reg, s2_lim_reg, s2_gm_reg;
    logic [31:0] s2_ax_reg, s2_ay_reg, s2_m2_reg;
    logic        s2_negx_reg, s2_negy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (en) begin
            s2_sqx_reg  <= 64'(s1_ax_reg) * 64'(s1_ax_reg);
            s2_sqy_reg  <= 64'(s1_ay_reg) * 64'(s1_ay_reg);
            s2_lim_reg  <= 64'(minsep_reg) * 64'(minsep_reg);
            s2_gm_reg   <= 64'(grav_reg) * 64'(s1_m1_reg);
            s2_ax_reg   <= s1_ax_reg;
            s2_ay_reg   <= s1_ay_reg;
            s2_m2_reg   <= s1_m2_reg;
            s2_negx_reg <= s1_negx_reg;
            s2_negy_reg <= s1_negy_reg;
        end
    end

    // Stage 3: squared distance, the too-close test, and G*m1*m2 as two partial products.
    logic [64:0] sum_sq;
    logic        s3_valid_reg;
    logic [64:0] s3_sum_reg;
    logic        s3_close_reg;
    logic [63:0] s3_gmlo_reg, s3_gmhi_reg;
    logic [31:0] s3_ax_reg, s3_ay_reg;
    logic        s3_negx_reg, s3_negy_reg;

    assign sum_sq = 65'(s2_sqx_reg) + 65'(s2_sqy_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (en) begin
            s3_sum_reg   <= sum_sq;
            s3_close_reg <= sum_sq <= 65'(s2_lim_reg);
            s3_gmlo_reg  <= 64'(s2_gm_reg[31:0]) * 64'(s2_m2_reg);
            s3_gmhi_reg  <= 64'(s2_gm_reg[63:32]) * 64'(s2_m2_reg);
            s3_ax_reg    <= s2_ax_reg;
            s3_ay_reg    <= s2_ay_reg;
            s3_negx_reg  <= s2_negx_reg;
            s3_negy_reg  <= s2_negy_reg;
        end
    end

    // Square root, one result bit per stage. Each stage keeps the partial root and
    // the remainder S - root^2, and takes the next bit when the remainder covers it.
    sqrt_stage_t sq_reg       [0:SQRT_STEPS];
    logic        sq_valid_reg [0:SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sq_valid_reg[0] <= s3_valid_reg;
        end
        if (en) begin
            sq_reg[0].rem   <= REM_W'(s3_sum_reg);
            sq_reg[0].root  <= '0;
            sq_reg[0].gmm   <= GMM_W'(s3_gmlo_reg) + (GMM_W'(s3_gmhi_reg) << 32);
            sq_reg[0].ax    <= s3_ax_reg;
            sq_reg[0].ay    <= s3_ay_reg;
            sq_reg[0].negx  <= s3_negx_reg;
            sq_reg[0].negy  <= s3_negy_reg;
            sq_reg[0].close <= s3_close_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - k;
        logic [TRIAL_W-1:0] trial;
        logic               take;
        sqrt_stage_t        sq_next;

        always_comb begin
            trial   = (TRIAL_W'(sq_reg[k].root) << (B + 1)) + (TRIAL_W'(1) << (2 * B));
            take    = TRIAL_W'(sq_reg[k].rem) >= trial;
            sq_next = sq_reg[k];
            if (take) begin
                sq_next.rem  = sq_reg[k].rem - REM_W'(trial);
                sq_next.root = sq_reg[k].root | (ROOT_W'(1) << B);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_valid_reg[k+1] <= sq_valid_reg[k];
            end
            if (en) begin
                sq_reg[k+1] <= sq_next;
            end
        end
    end

    // Multiply stages: d^2 and the numerator partial products, then the d^3 partial
    // products and the numerators, then the full denominator d^3.
    sqrt_stage_t       sq_last;
    logic              m1_valid_reg, m2_valid_reg, m3_valid_reg;
    logic [2*ROOT_W-1:0] m1_d2_reg;
    logic [ROOT_W-1:0] m1_d_reg;
    logic [63:0]       m1_px_reg [3];
    logic [63:0]       m1_py_reg [3];
    logic [2*ROOT_W-1:0] m2_d3a_reg, m2_d3b_reg;
    logic [NUM_W-1:0]  m2_numx_reg, m2_numy_reg, m3_numx_reg, m3_numy_reg;
    logic [DEN_W-1:0]  m3_den_reg;
    logic              m1_negx_reg, m1_negy_reg, m1_close_reg;
    logic              m2_negx_reg, m2_negy_reg, m2_close_reg;
    logic              m3_negx_reg, m3_negy_reg, m3_close_reg;

    assign sq_last = sq_reg[SQRT_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= sq_valid_reg[SQRT_STEPS];
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
        if (en) begin
            m1_d2_reg    <= (2*ROOT_W)'(sq_last.root) * (2*ROOT_W)'(sq_last.root);
            m1_d_reg     <= sq_last.root;
            for (int i = 0; i < 3; i++) begin
                m1_px_reg[i] <= 64'(sq_last.gmm[32*i +: 32]) * 64'(sq_last.ax);
                m1_py_reg[i] <= 64'(sq_last.gmm[32*i +: 32]) * 64'(sq_last.ay);
            end
            m1_negx_reg  <= sq_last.negx;
            m1_negy_reg  <= sq_last.negy;
            m1_close_reg <= sq_last.close;

            m2_d3a_reg   <= (2*ROOT_W)'(m1_d2_reg[ROOT_W-1:0]) * (2*ROOT_W)'(m1_d_reg);
            m2_d3b_reg   <= (2*ROOT_W)'(m1_d2_reg[2*ROOT_W-1:ROOT_W]) * (2*ROOT_W)'(m1_d_reg);
            m2_numx_reg  <= NUM_W'(m1_px_reg[0]) + (NUM_W'(m1_px_reg[1]) << 32)
                          + (NUM_W'(m1_px_reg[2]) << 64);
            m2_numy_reg  <= NUM_W'(m1_py_reg[0]) + (NUM_W'(m1_py_reg[1]) << 32)
                          + (NUM_W'(m1_py_reg[2]) << 64);
            m2_negx_reg  <= m1_negx_reg;
            m2_negy_reg  <= m1_negy_reg;
            m2_close_reg <= m1_close_reg;

            m3_den_reg   <= DEN_W'(m2_d3a_reg) + (DEN_W'(m2_d3b_reg) << ROOT_W);
            m3_numx_reg  <= m2_numx_reg;
            m3_numy_reg  <= m2_numy_reg;
            m3_negx_reg  <= m2_negx_reg;
            m3_negy_reg  <= m2_negy_reg;
            m3_close_reg <= m2_close_reg;
        end
    end

    // Division. The numerator is G*m1*m2*|delta|*2^16; its bits above 63 compared
    // with d^3 tell at once whether the quotient overflows 64 bits. Otherwise those
    // bits are the starting remainder and one quotient bit is produced per stage.
    div_stage_t dv_reg [0:DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en) begin
            div_valid_reg[0] <= m3_valid_reg;
        end
        if (en) begin
            dv_reg[0].rx    <= RDIV_W'(m3_numx_reg[NUM_W-1:NUM_HI_LSB]);
            dv_reg[0].ry    <= RDIV_W'(m3_numy_reg[NUM_W-1:NUM_HI_LSB]);
            dv_reg[0].lowx  <= {m3_numx_reg[NUM_HI_LSB-1:0], 16'd0};
            dv_reg[0].lowy  <= {m3_numy_reg[NUM_HI_LSB-1:0], 16'd0};
            dv_reg[0].qx    <= '0;
            dv_reg[0].qy    <= '0;
            dv_reg[0].den   <= m3_den_reg;
            dv_reg[0].bigx  <= RDIV_W'(m3_numx_reg[NUM_W-1:NUM_HI_LSB]) >= RDIV_W'(m3_den_reg);
            dv_reg[0].bigy  <= RDIV_W'(m3_numy_reg[NUM_W-1:NUM_HI_LSB]) >= RDIV_W'(m3_den_reg);
            dv_reg[0].negx  <= m3_negx_reg;
            dv_reg[0].negy  <= m3_negy_reg;
            dv_reg[0].close <= m3_close_reg;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [RDIV_W-1:0] shx, shy;
        logic              tx, ty;
        div_stage_t        dv_next;

        always_comb begin
            shx          = {dv_reg[k].rx[RDIV_W-2:0], dv_reg[k].lowx[Q_W-1]};
            shy          = {dv_reg[k].ry[RDIV_W-2:0], dv_reg[k].lowy[Q_W-1]};
            tx           = shx >= RDIV_W'(dv_reg[k].den);
            ty           = shy >= RDIV_W'(dv_reg[k].den);
            dv_next      = dv_reg[k];
            dv_next.rx   = tx ? shx - RDIV_W'(dv_reg[k].den) : shx;
            dv_next.ry   = ty ? shy - RDIV_W'(dv_reg[k].den) : shy;
            dv_next.lowx = {dv_reg[k].lowx[Q_W-2:0], 1'b0};
            dv_next.lowy = {dv_reg[k].lowy[Q_W-2:0], 1'b0};
            dv_next.qx   = {dv_reg[k].qx[Q_W-2:0], tx};
            dv_next.qy   = {dv_reg[k].qy[Q_W-2:0], ty};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                div_valid_reg[k+1] <= div_valid_reg[k];
            end
            if (en) begin
                dv_reg[k+1] <= dv_next;
            end
        end
    end

    // Sign and saturation. A negative result may reach -2^63; a positive one stops
    // at 2^63-1.
    function automatic logic [Q_W-1:0] clamp_force(input logic [Q_W-1:0] q,
                                                   input logic big, input logic neg);
        logic [Q_W-1:0] mag;
        begin
            if (neg) begin
                mag = (big || q > FORCE_NEG_MAG) ? FORCE_NEG_MAG : q;
                clamp_force = ~mag + Q_W'(1);
            end else begin
                clamp_force = (big || q[Q_W-1]) ? FORCE_POS_MAX : q;
            end
        end
    endfunction

    div_stage_t     fin;
    logic [Q_W-1:0] f1x_next, f1y_next, f2x_next, f2y_next;
    logic           sat_next;
    logic [Q_W-1:0] f1x_reg, f1y_reg, f2x_reg, f2y_reg;
    logic           active_reg, sat_reg;

    always_comb begin
        fin      = dv_reg[DIV_STEPS];
        f1x_next = '0;
        f1y_next = '0;
        f2x_next = '0;
        f2y_next = '0;
        sat_next = 1'b0;
        if (!fin.close) begin
            f1x_next = clamp_force(fin.qx, fin.bigx, fin.negx);
            f2x_next = clamp_force(fin.qx, fin.bigx, ~fin.negx);
            f1y_next = clamp_force(fin.qy, fin.bigy, fin.negy);
            f2y_next = clamp_force(fin.qy, fin.bigy, ~fin.negy);
            sat_next = fin.bigx | fin.qx[Q_W-1] | fin.bigy | fin.qy[Q_W-1];
        end
    end

    // Output register: loads whenever it is empty or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= div_valid_reg[DIV_STEPS];
        end
        if (out_free) begin
            f1x_reg    <= f1x_next;
            f1y_reg    <= f1y_next;
            f2x_reg    <= f2x_next;
            f2y_reg    <= f2y_next;
            active_reg <= ~fin.close;
            sat_reg    <= sat_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_first_force_x  = f1x_reg;
    assign m_first_force_y  = f1y_reg;
    assign m_second_force_x = f2x_reg;
    assign m_second_force_y = f2y_reg;
    assign m_force_active   = active_reg;
    assign m_saturated      = sat_reg;

endmodule
